>>> rtl/icdf_pkg.sv
// shared types, constants and codes for the inverse cdf table lookup unit
// no dependencies; imported by every module of the block
`default_nettype none

package icdf_pkg;

    // table geometry
    localparam int TABLE_SIZE = 1024;
    localparam int MAX_ROWS   = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ADDR_W     = ROW_W + IDX_W;
    localparam int DEPTH      = MAX_ROWS * TABLE_SIZE;

    // field widths
    localparam int OP_W      = 2;
    localparam int ROWIN_W   = 4;
    localparam int ENTIN_W   = 10;
    localparam int AGE_W     = 38;
    localparam int CNT_W     = 32;
    localparam int Z_W       = 32;
    localparam int UNI_W     = 32;
    localparam int EVT_W     = 16;
    localparam int MASS_W    = 32;
    localparam int ST_W      = 3;
    localparam int MODEL_W   = 2;
    localparam int ASSOC_W   = 8;
    localparam int RIU_W     = 5;
    localparam int CFG_IDX_W = 2;

    // input tdata layout, lowest bit first
    localparam int OFF_ROW  = 0;
    localparam int OFF_ENT  = OFF_ROW + ROWIN_W;
    localparam int OFF_AGE  = OFF_ENT + ENTIN_W;
    localparam int OFF_CNT  = OFF_AGE + AGE_W;
    localparam int OFF_GZ   = OFF_CNT + CNT_W;
    localparam int OFF_UNI  = OFF_GZ + Z_W;
    localparam int OFF_EVT  = OFF_UNI + UNI_W;
    localparam int OFF_MASS = OFF_EVT + EVT_W;
    localparam int OFF_LZ   = OFF_MASS + MASS_W;
    localparam int IN_BITS  = OFF_LZ + Z_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((AGE_W + 7) / 8) * 8;

    // arithmetic
    localparam int PROD_W = 64;
    localparam int MUL_W  = 32;
    localparam int AU_W   = ASSOC_W + UNI_W;
    localparam int AC_W   = ASSOC_W + EVT_W;
    localparam int TQ_W   = PROD_W - 8;
    localparam int DEN_W  = 32;
    localparam int FRAC_W = 25;
    localparam int QUO_W  = FRAC_W + 1;
    localparam int QCNT_W = $clog2(QUO_W);

    localparam logic [AGE_W-1:0] LATE_AGE_RST = 38'd138000000000;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY      = 2'd0,
        OP_LOAD_ENTRY = 2'd1,
        OP_LOAD_ROW   = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_INTERP    = 3'd0,
        ST_BELOW     = 3'd1,
        ST_BEYOND    = 3'd2,
        ST_LOAD_DONE = 3'd3,
        ST_BAD_MODEL = 3'd4
    } t_status;

    typedef enum logic [MODEL_W-1:0] {
        MODEL_METAL    = 2'd0,
        MODEL_SINGLE_A = 2'd1,
        MODEL_SINGLE_B = 2'd2,
        MODEL_INVALID  = 2'd3
    } t_model;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL = 2'd0,
        CFG_ASSOC = 2'd1,
        CFG_ROWS  = 2'd2,
        CFG_LATE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_TA, S_TB, S_TC, S_Z0, S_ZN, S_ZSCAN,
        S_PRD, S_PMUL, S_PCMP, S_ALO, S_AHI, S_AWT,
        S_RLERP, S_RFIN, S_ZLERP, S_DONE
    } t_state;

    typedef enum logic [1:0] {PR_FIRST, PR_LAST, PR_MID} t_probe;

    typedef enum logic [1:0] {PASS_SINGLE, PASS_UPPER, PASS_LOWER} t_pass;

    typedef enum logic [2:0] {LS_IDLE, LS_NORM, LS_DIV, LS_MUL, LS_ADD} t_lerp_state;

    typedef struct packed {
        logic              start;
        logic [AGE_W-1:0]  a;
        logic [AGE_W-1:0]  b;
        logic [PROD_W-1:0] num;
        logic [PROD_W-1:0] den;
    } t_lerp_req;

    typedef struct packed {
        logic             done;
        logic [AGE_W-1:0] age;
    } t_lerp_rsp;

endpackage

`default_nettype wire

>>> rtl/inverse_cdf_table_lookup_unit.sv
// top level of the inverse cdf table lookup unit: table memories, sequencer,
// shared 32x32 multiplier and compare; depends on icdf_pkg and icdf_lerp
`default_nettype none

// Each transaction on the slave stream is one item, each item gives exactly
// one result transaction on the master stream. Loads (entry or row grid
// point) and the unused op go from acceptance straight to the done state,
// which loads the result register as soon as the output register is free;
// the block then takes the next item. A query runs a sequencer around one
// shared 32x32 multiplier and the single read port of the table memories:
// it forms the target, then probes (address, multiply, compare) the first
// entry, the last entry and up to log2(TABLE_SIZE) bisection points, reads
// two ages, requests an interpolation and waits while the interpolation
// unit normalizes, divides bit-serially one quotient bit per step, scales,
// adds and hands the age back. A target below the first entry returns that
// entry's age and one on a flat segment the lower entry's age, one past the
// last entry returns the late age, and an invalid model ends the query once
// the target is formed. In metallicity mode a search of the grid points
// comes first and, when the value lies between two grid points, a second
// row lookup and an interpolation in log metallicity follow. The input
// stream is not ready while an item is in work; a finished result sits in
// an output register, so the next item is taken while it waits. Config
// writes are always accepted and must only happen while the block is idle.
// Table entries never loaded read back as arbitrary data.

module inverse_cdf_table_lookup_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: row_index, entry_index, age_word, count_word, grid_log_z,
    //        uniform, event_count, initial_mass, log_metallicity, zero pad
    input  logic [icdf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op
    input  logic [icdf_pkg::OP_W-1:0]        s_axis_tuser,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: explosion_age, zero pad
    output logic [icdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [icdf_pkg::ST_W-1:0]        m_axis_tuser,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [icdf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [icdf_pkg::AGE_W-1:0]       i_cfg_data
);
    import icdf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // config registers
    t_model              r_model;
    logic [ASSOC_W-1:0]  r_assoc;
    logic [RIU_W-1:0]    r_rows;
    logic [AGE_W-1:0]    r_late;

    // table storage
    logic [AGE_W-1:0]        age_mem [DEPTH];
    logic [CNT_W-1:0]        cnt_mem [DEPTH];
    logic signed [Z_W-1:0]   row_z   [MAX_ROWS];
    logic [AGE_W-1:0]        r_age_q;
    logic [CNT_W-1:0]        r_cnt_q;

    // sequencer
    t_state                  r_state, n_state;
    t_probe                  r_kind;
    t_pass                   r_pass;
    logic [ROW_W-1:0]        r_row, r_zi;
    logic [IDX_W-1:0]        r_lo, r_hi;
    logic [PROD_W-1:0]       r_plo, r_phi, r_t, r_prod;
    logic [AU_W-1:0]         r_tlo;
    logic                    r_aonly;
    logic [AGE_W-1:0]        r_a, r_a1, r_row_age, r_res_age;
    t_status                 r_row_st, r_s1, r_res_st;

    // latched query fields
    logic [UNI_W-1:0]        r_uni;
    logic [EVT_W-1:0]        r_evt;
    logic [MASS_W-1:0]       r_mass;
    logic signed [Z_W-1:0]   r_logz, r_gprev, r_zlo, r_zhi;

    // output register
    logic                    r_out_valid;
    logic [AGE_W-1:0]        r_out_age;
    t_status                 r_out_st;

    // decoded input fields
    logic                    acc;
    t_op                     in_op;
    logic [ROWIN_W-1:0]      in_row;
    logic [ENTIN_W-1:0]      in_ent;
    logic                    ent_we, row_we;
    logic [ADDR_W-1:0]       wr_addr;

    // shared datapath
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [ADDR_W-1:0]       rd_addr;
    logic [IDX_W-1:0]        rd_ent;
    logic [ROW_W-1:0]        zrd;
    logic signed [Z_W-1:0]   g_rd;
    logic [ROW_W-1:0]        last_row;
    logic                    cmp_lt, cmp_gt;
    logic [IDX_W:0]          mid_sum;
    logic [IDX_W-1:0]        mid, lo_nx, hi_nx;
    logic [PROD_W-1:0]       plo_nx, phi_nx;
    logic                    gap_more;
    logic [TQ_W-1:0]         t_sum;
    logic [Z_W:0]            zd_num, zd_den;
    logic                    out_free;
    t_status                 pair_st;
    t_lerp_req               lreq;
    t_lerp_rsp               lrsp;

    assign acc    = s_axis_tvalid && s_axis_tready;
    assign in_op  = t_op'(s_axis_tuser);
    assign in_row = s_axis_tdata[OFF_ROW +: ROWIN_W];
    assign in_ent = s_axis_tdata[OFF_ENT +: ENTIN_W];

    // loads outside the table write nothing but still answer
    assign ent_we  = acc && (in_op == OP_LOAD_ENTRY) && (32'(in_row) < MAX_ROWS)
                     && (32'(in_ent) < TABLE_SIZE);
    assign row_we  = acc && (in_op == OP_LOAD_ROW) && (32'(in_row) < MAX_ROWS);
    assign wr_addr = {ROW_W'(in_row), IDX_W'(in_ent)};

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    // row count clamped to 1..MAX_ROWS
    always_comb begin
        if (r_rows == '0) begin
            last_row = '0;
        end else if (32'(r_rows) > MAX_ROWS) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_rows - 1'b1);
        end
    end

    // bisection bookkeeping
    assign cmp_lt   = (r_t < r_prod);
    assign cmp_gt   = (r_t > r_prod);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[IDX_W:1];
    assign lo_nx    = cmp_gt ? mid : r_lo;
    assign hi_nx    = cmp_gt ? r_hi : mid;
    assign plo_nx   = cmp_gt ? r_prod : r_plo;
    assign phi_nx   = cmp_gt ? r_phi : r_prod;
    assign gap_more = ((hi_nx - lo_nx) > IDX_W'(1));

    // target = association * (count + uniform), Q.40
    assign t_sum = {r_prod[AC_W-1:0], {UNI_W{1'b0}}} + TQ_W'(r_tlo);

    // log metallicity distances, both non-negative inside a bracket
    assign zd_num = {r_logz[Z_W-1], r_logz} - {r_zlo[Z_W-1], r_zlo};
    assign zd_den = {r_zhi[Z_W-1], r_zhi} - {r_zlo[Z_W-1], r_zlo};

    // worst status of the two bracketing rows
    always_comb begin
        if ((r_row_st == ST_BEYOND) || (r_s1 == ST_BEYOND)) begin
            pair_st = ST_BEYOND;
        end else if ((r_row_st == ST_BELOW) || (r_s1 == ST_BELOW)) begin
            pair_st = ST_BELOW;
        end else begin
            pair_st = ST_INTERP;
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = r_mass;
        mul_b = r_cnt_q;
        case (r_state)
            S_TA: begin
                mul_a = MUL_W'(r_assoc);
                mul_b = r_uni;
            end
            S_TB: begin
                mul_a = MUL_W'(r_assoc);
                mul_b = MUL_W'(r_evt);
            end
            default: ;
        endcase
    end

    // table read address
    always_comb begin
        rd_ent = r_lo;
        case (r_state)
            S_PRD: begin
                case (r_kind)
                    PR_FIRST: rd_ent = '0;
                    PR_LAST:  rd_ent = LAST_IDX;
                    default:  rd_ent = mid;
                endcase
            end
            S_AHI:   rd_ent = r_hi;
            default: rd_ent = r_lo;
        endcase
        rd_addr = {r_row, rd_ent};
    end

    // grid point read
    always_comb begin
        case (r_state)
            S_Z0:    zrd = '0;
            S_ZN:    zrd = last_row;
            default: zrd = r_zi;
        endcase
        g_rd = row_z[zrd];
    end

    // interpolation requests: ages within a row, then rows in log metallicity
    always_comb begin
        lreq.start = 1'b0;
        lreq.a     = r_a;
        lreq.b     = r_age_q;
        lreq.num   = r_t - r_plo;
        lreq.den   = r_phi - r_plo;
        if (r_state == S_AWT) begin
            lreq.start = 1'b1;
        end else if (r_state == S_RFIN) begin
            lreq.start = (r_pass == PASS_LOWER);
            lreq.a     = r_row_age;
            lreq.b     = r_a1;
            lreq.num   = PROD_W'(zd_num);
            lreq.den   = PROD_W'(zd_den);
        end
    end

    icdf_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lreq),
        .o_rsp   (lrsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (in_op == OP_QUERY) ? S_TA : S_DONE;
                end
            end
            S_TA: n_state = S_TB;
            S_TB: n_state = S_TC;
            S_TC: begin
                unique case (r_model)
                    MODEL_INVALID: n_state = S_DONE;
                    MODEL_METAL:   n_state = S_Z0;
                    default:       n_state = S_PRD;
                endcase
            end
            S_Z0:    n_state = (r_logz <= g_rd) ? S_PRD : S_ZN;
            S_ZN:    n_state = (r_logz >= g_rd) ? S_PRD : S_ZSCAN;
            S_ZSCAN: n_state = (g_rd > r_logz) ? S_PRD : S_ZSCAN;
            S_PRD:   n_state = S_PMUL;
            S_PMUL:  n_state = S_PCMP;
            S_PCMP: begin
                unique case (r_kind)
                    PR_FIRST: n_state = cmp_lt ? S_ALO : S_PRD;
                    PR_LAST:  n_state = cmp_gt ? S_RFIN : S_PRD;
                    default:  n_state = gap_more ? S_PRD : S_ALO;
                endcase
            end
            S_ALO:   n_state = S_AHI;
            S_AHI:   n_state = r_aonly ? S_RFIN : S_AWT;
            S_AWT:   n_state = S_RLERP;
            S_RLERP: if (lrsp.done) n_state = S_RFIN;
            S_RFIN: begin
                unique case (r_pass)
                    PASS_UPPER: n_state = S_PRD;
                    PASS_LOWER: n_state = S_ZLERP;
                    default:    n_state = S_DONE;
                endcase
            end
            S_ZLERP: if (lrsp.done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_model     <= MODEL_SINGLE_A;
            r_assoc     <= ASSOC_W'(1);
            r_rows      <= RIU_W'(1);
            r_late      <= LATE_AGE_RST;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MODEL: r_model <= t_model'(i_cfg_data[MODEL_W-1:0]);
                    CFG_ASSOC: r_assoc <= i_cfg_data[ASSOC_W-1:0];
                    CFG_ROWS:  r_rows  <= i_cfg_data[RIU_W-1:0];
                    CFG_LATE:  r_late  <= i_cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // table memories, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            age_mem[wr_addr] <= s_axis_tdata[OFF_AGE +: AGE_W];
            cnt_mem[wr_addr] <= s_axis_tdata[OFF_CNT +: CNT_W];
        end
        r_age_q <= age_mem[rd_addr];
        r_cnt_q <= cnt_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_z[ROW_W'(in_row)] <= s_axis_tdata[OFF_GZ +: Z_W];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_age <= r_res_age;
            r_out_st  <= r_res_st;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (r_state)
            S_IDLE: begin
                r_uni     <= s_axis_tdata[OFF_UNI +: UNI_W];
                r_evt     <= s_axis_tdata[OFF_EVT +: EVT_W];
                r_mass    <= s_axis_tdata[OFF_MASS +: MASS_W];
                r_logz    <= s_axis_tdata[OFF_LZ +: Z_W];
                r_res_age <= '0;
                r_res_st  <= ST_LOAD_DONE;
            end
            S_TB: r_tlo <= r_prod[AU_W-1:0];
            S_TC: begin
                r_t       <= {t_sum, 8'b0};
                r_res_age <= '0;
                r_res_st  <= ST_BAD_MODEL;
                r_row     <= '0;
                r_kind    <= PR_FIRST;
                r_pass    <= PASS_SINGLE;
            end
            S_Z0: begin
                r_gprev <= g_rd;
                r_zi    <= ROW_W'(1);
            end
            S_ZN: begin
                if (r_logz >= g_rd) begin
                    r_row <= last_row;
                end
            end
            S_ZSCAN: begin
                if (g_rd > r_logz) begin
                    // bracket found, upper row first
                    r_zlo  <= r_gprev;
                    r_zhi  <= g_rd;
                    r_row  <= r_zi;
                    r_pass <= PASS_UPPER;
                end else begin
                    r_gprev <= g_rd;
                    r_zi    <= r_zi + 1'b1;
                end
            end
            S_PCMP: begin
                case (r_kind)
                    PR_FIRST: begin
                        r_lo <= '0;
                        if (cmp_lt) begin
                            r_aonly  <= 1'b1;
                            r_row_st <= ST_BELOW;
                        end else begin
                            r_plo  <= r_prod;
                            r_kind <= PR_LAST;
                        end
                    end
                    PR_LAST: begin
                        if (cmp_gt) begin
                            r_row_age <= r_late;
                            r_row_st  <= ST_BEYOND;
                        end else begin
                            r_phi    <= r_prod;
                            r_hi     <= LAST_IDX;
                            r_kind   <= PR_MID;
                            r_row_st <= ST_INTERP;
                        end
                    end
                    default: begin
                        r_lo    <= lo_nx;
                        r_hi    <= hi_nx;
                        r_plo   <= plo_nx;
                        r_phi   <= phi_nx;
                        // flat segment returns the lower age as is
                        r_aonly <= (phi_nx <= plo_nx);
                    end
                endcase
            end
            S_AHI: begin
                r_a <= r_age_q;
                if (r_aonly) begin
                    r_row_age <= r_age_q;
                end
            end
            S_RLERP: begin
                if (lrsp.done) begin
                    r_row_age <= lrsp.age;
                end
            end
            S_RFIN: begin
                case (r_pass)
                    PASS_UPPER: begin
                        r_a1   <= r_row_age;
                        r_s1   <= r_row_st;
                        r_row  <= r_zi - 1'b1;
                        r_kind <= PR_FIRST;
                        r_pass <= PASS_LOWER;
                    end
                    PASS_LOWER: r_res_st <= pair_st;
                    default: begin
                        r_res_age <= r_row_age;
                        r_res_st  <= r_row_st;
                    end
                endcase
            end
            S_ZLERP: begin
                if (lrsp.done) begin
                    r_res_age <= lrsp.age;
                end
            end
            default: ;
        endcase
        // every row lookup restarts the probe sequence with a clean age-only flag
        if ((r_state == S_TC) || (r_state == S_RFIN)) begin
            r_aonly <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - AGE_W){1'b0}}, r_out_age};
    assign m_axis_tuser  = r_out_st;

endmodule

`default_nettype wire

>>> rtl/icdf_lerp.sv
// linear age interpolation a + (b-a)*num/den with a bit-serial divider
// depends on icdf_pkg
`default_nettype none

module icdf_lerp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  icdf_pkg::t_lerp_req i_req,
    output icdf_pkg::t_lerp_rsp o_rsp
);
    import icdf_pkg::*;

    t_lerp_state         r_state, n_state;
    logic [AGE_W-1:0]    r_a, r_b, r_age;
    logic [PROD_W-1:0]   r_num, r_den;
    logic [DEN_W:0]      r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [QCNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;
    logic                r_done;

    logic                norm_done;
    logic                rem_ge;
    logic [DEN_W:0]      rem_sub;
    logic [DEN_W-1:0]    num_clamp;
    logic [AGE_W-1:0]    diff;
    logic [AGE_W-1:0]    step;

    assign norm_done = (r_den[PROD_W-1:DEN_W] == '0);
    assign rem_ge    = (r_rem >= {1'b0, r_den[DEN_W-1:0]});
    assign rem_sub   = rem_ge ? (r_rem - {1'b0, r_den[DEN_W-1:0]}) : r_rem;
    assign num_clamp = (r_num[DEN_W-1:0] > r_den[DEN_W-1:0]) ? r_den[DEN_W-1:0]
                                                              : r_num[DEN_W-1:0];
    assign diff      = (r_b >= r_a) ? (r_b - r_a) : (r_a - r_b);
    assign step      = r_prod[FRAC_W +: AGE_W];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LS_IDLE: begin
                if (i_req.start && (i_req.den != '0)) begin
                    n_state = LS_NORM;
                end
            end
            LS_NORM: if (norm_done) n_state = LS_DIV;
            LS_DIV:  if (r_cnt == '0) n_state = LS_MUL;
            LS_MUL:  n_state = LS_ADD;
            LS_ADD:  n_state = LS_IDLE;
            default: n_state = LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == LS_ADD) ||
                       ((r_state == LS_IDLE) && i_req.start && (i_req.den == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            LS_IDLE: begin
                r_a   <= i_req.a;
                r_b   <= i_req.b;
                r_num <= i_req.num;
                r_den <= i_req.den;
                if (i_req.start) begin
                    r_age <= i_req.a;
                end
            end
            LS_NORM: begin
                if (!norm_done) begin
                    r_num <= r_num >> 1;
                    r_den <= r_den >> 1;
                end else begin
                    r_rem <= {1'b0, num_clamp};
                    r_quo <= '0;
                    r_cnt <= QCNT_W'(QUO_W - 1);
                end
            end
            LS_DIV: begin
                // one quotient bit per cycle, integer bit first
                r_quo <= {r_quo[QUO_W-2:0], rem_ge};
                r_rem <= {rem_sub[DEN_W-1:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            LS_MUL: begin
                r_prod <= PROD_W'(diff) * PROD_W'(r_quo);
                r_neg  <= (r_b < r_a);
            end
            LS_ADD: begin
                r_age <= r_neg ? (r_a - step) : (r_a + step);
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.age  = r_age;

endmodule

`default_nettype wire

>>> rtl/icdf_checker.sv
// port-level checker for the inverse cdf table lookup unit, bound to the top
// depends on icdf_pkg and inverse_cdf_table_lookup_unit
`default_nettype none

module icdf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [icdf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [icdf_pkg::OP_W-1:0]        s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [icdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [icdf_pkg::ST_W-1:0]        m_axis_tuser,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [icdf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [icdf_pkg::AGE_W-1:0]       i_cfg_data
);
    import icdf_pkg::*;

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // a result transaction stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one item in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !s_axis_tready)
        else $error("new item taken while busy");

    // non-query items taken while the output is empty answer load done
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (s_axis_tuser != OP_QUERY) && !m_axis_tvalid
        |-> ##2 (m_axis_tvalid && (m_axis_tuser == ST_LOAD_DONE)))
        else $error("load item not answered");

endmodule

bind inverse_cdf_table_lookup_unit icdf_checker u_icdf_checker (.*);

`default_nettype wire

>>> tb/sv/inverse_cdf_table_lookup_unit_check.sv
// checker for the inverse cdf table lookup unit: watches the streams and config
// channel, predicts each result and compares it; depends on icdf_pkg
`default_nettype none

module inverse_cdf_table_lookup_unit_check
    import icdf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [OP_W-1:0]        i_in_op,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic [ST_W-1:0]        i_out_status,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [AGE_W-1:0]       i_cfg_data,
    output int                     o_fail_count,
    output int                     o_open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [AGE_W-1:0] age;
        t_status          st;
    } t_answer;

    // predictor copy of the table and registers
    logic [AGE_W-1:0]    age_mem [DEPTH];
    logic [CNT_W-1:0]    cnt_mem [DEPTH];
    logic signed [31:0]  grid_z  [MAX_ROWS];
    t_model              model_q;
    logic [ASSOC_W-1:0]  assoc_q;
    logic [RIU_W-1:0]    rows_q;
    logic [AGE_W-1:0]    late_q;
    t_answer             answer_q [$];

    initial begin
        o_fail_count = 0;
        o_open_count = 0;
    end

    function automatic logic [AGE_W-1:0] blend_age(input logic [AGE_W-1:0] a,
            input logic [AGE_W-1:0] b, input logic [63:0] num, input logic [63:0] den);
        logic [63:0] n, d, f;
        if (den == 0) return a;
        n = num;
        d = den;
        while (d >= 64'h1_0000_0000) begin
            d = d >> 1;
            n = n >> 1;
        end
        if (n > d) n = d;
        f = (n << FRAC_W) / d;
        if (b >= a) return a + AGE_W'((64'(b - a) * f) >> FRAC_W);
        return a - AGE_W'((64'(a - b) * f) >> FRAC_W);
    endfunction

    // bisection of one row for the target against mass times count
    function automatic logic [AGE_W-1:0] search_row(input int row, input logic [63:0] tgt,
            input logic [63:0] mass, output t_status st);
        int base, lo, hi, mid;
        logic [63:0] plo, phi;
        base = row * TABLE_SIZE;
        lo = 0;
        hi = TABLE_SIZE - 1;
        if (tgt < mass * 64'(cnt_mem[base])) begin
            st = ST_BELOW;
            return age_mem[base];
        end
        if (tgt > mass * 64'(cnt_mem[base + hi])) begin
            st = ST_BEYOND;
            return late_q;
        end
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (tgt > mass * 64'(cnt_mem[base + mid])) lo = mid;
            else hi = mid;
        end
        st = ST_INTERP;
        plo = mass * 64'(cnt_mem[base + lo]);
        phi = mass * 64'(cnt_mem[base + hi]);
        if (phi <= plo) return age_mem[base + lo];
        return blend_age(age_mem[base + lo], age_mem[base + hi], tgt - plo, phi - plo);
    endfunction

    function automatic t_answer next_event_age(input logic [IN_TDATA_W-1:0] d);
        t_answer r;
        logic [63:0] tgt, mass;
        logic signed [31:0] z;
        int n, idx;
        t_status s0, s1;
        logic [AGE_W-1:0] a0, a1;
        tgt  = (64'(assoc_q) * ((64'(d[OFF_EVT +: EVT_W]) << 32)
                + 64'(d[OFF_UNI +: UNI_W]))) << 8;
        mass = 64'(d[OFF_MASS +: MASS_W]);
        z    = d[OFF_LZ +: Z_W];
        r.age = '0;
        r.st  = ST_BAD_MODEL;
        case (model_q)
            MODEL_SINGLE_A, MODEL_SINGLE_B: r.age = search_row(0, tgt, mass, r.st);
            MODEL_METAL: begin
                n = int'(rows_q);
                if (n == 0) n = 1;
                if (n > MAX_ROWS) n = MAX_ROWS;
                if (z <= grid_z[0]) r.age = search_row(0, tgt, mass, r.st);
                else if (z >= grid_z[n-1]) r.age = search_row(n - 1, tgt, mass, r.st);
                else begin
                    idx = 0;
                    for (int i = 1; i < n; i++) begin
                        if (grid_z[i] > z) begin
                            idx = i - 1;
                            break;
                        end
                    end
                    a1 = search_row(idx + 1, tgt, mass, s1);
                    a0 = search_row(idx, tgt, mass, s0);
                    if (s0 == ST_BEYOND || s1 == ST_BEYOND) r.st = ST_BEYOND;
                    else if (s0 == ST_BELOW || s1 == ST_BELOW) r.st = ST_BELOW;
                    else r.st = ST_INTERP;
                    r.age = blend_age(a0, a1, 64'(longint'(z) - longint'(grid_z[idx])),
                        64'(longint'(grid_z[idx+1]) - longint'(grid_z[idx])));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_op op;
        int addr;
        if (!i_rst_n) begin
            model_q = MODEL_SINGLE_A;
            assoc_q = 1;
            rows_q  = 1;
            late_q  = LATE_AGE_RST;
            answer_q.delete();
        end else begin
            // results first: an answer leaving now belongs to an older transaction
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t unexpected result age %0d status %0d", $time,
                        i_out_data[AGE_W-1:0], i_out_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (i_out_data[AGE_W-1:0] !== want.age || i_out_status !== want.st) begin
                        $display("%0t mismatch: expected age %0d status %0d, got age %0d status %0d",
                            $time, want.age, want.st, i_out_data[AGE_W-1:0], i_out_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MODEL: model_q = t_model'(i_cfg_data[MODEL_W-1:0]);
                    CFG_ASSOC: assoc_q = i_cfg_data[ASSOC_W-1:0];
                    CFG_ROWS:  rows_q  = i_cfg_data[RIU_W-1:0];
                    CFG_LATE:  late_q  = i_cfg_data;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                op = t_op'(i_in_op);
                want.age = '0;
                want.st  = ST_LOAD_DONE;
                case (op)
                    OP_LOAD_ENTRY: begin
                        addr = int'(i_in_data[OFF_ROW +: ROWIN_W]) * TABLE_SIZE
                             + int'(i_in_data[OFF_ENT +: ENTIN_W]);
                        age_mem[addr] = i_in_data[OFF_AGE +: AGE_W];
                        cnt_mem[addr] = i_in_data[OFF_CNT +: CNT_W];
                    end
                    OP_LOAD_ROW: grid_z[i_in_data[OFF_ROW +: ROWIN_W]] = i_in_data[OFF_GZ +: Z_W];
                    OP_QUERY:    want = next_event_age(i_in_data);
                    default: ;
                endcase
                answer_q.push_back(want);
            end
        end
        o_open_count <= answer_q.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/inverse_cdf_table_lookup_unit_test.sv
// testbench top for the inverse cdf table lookup unit: clock, reset, stimulus
// and verdict; depends on icdf_pkg, the block and inverse_cdf_table_lookup_unit_check
`default_nettype none

module inverse_cdf_table_lookup_unit_test;
    import icdf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]        m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [AGE_W-1:0]       i_cfg_data = '0;

    int fail_count, open_count;
    int src_idle_pct = 0;   // chance per cycle that the sender holds back
    int snk_idle_pct = 0;   // chance per cycle that the receiver holds back
    bit hold_req = 1'b0;    // asks the receiver for one long stall

    // stimulus-side copy of the settings that shape the queries
    logic [ASSOC_W-1:0] cur_assoc = 1;
    int                 cur_rows = 1;

    inverse_cdf_table_lookup_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    inverse_cdf_table_lookup_unit_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_status (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // overall limit, far above the slowest legal run
    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end

    // receiver: random back-pressure plus one long stall on request
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(input logic [3:0] row,
            input logic [9:0] ent, input logic [AGE_W-1:0] age, input logic [31:0] cnt,
            input logic [31:0] gz, input logic [31:0] uni, input logic [15:0] evt,
            input logic [31:0] mass, input logic [31:0] lz);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[OFF_ROW +: ROWIN_W] = row;
        d[OFF_ENT +: ENTIN_W] = ent;
        d[OFF_AGE +: AGE_W]   = age;
        d[OFF_CNT +: CNT_W]   = cnt;
        d[OFF_GZ +: Z_W]      = gz;
        d[OFF_UNI +: UNI_W]   = uni;
        d[OFF_EVT +: EVT_W]   = evt;
        d[OFF_MASS +: MASS_W] = mass;
        d[OFF_LZ +: Z_W]      = lz;
        return d;
    endfunction

    // one transaction on the input stream; valid stays high into the next call
    task automatic send_item(input t_op op, input logic [IN_TDATA_W-1:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_query(input logic [31:0] uni, input logic [15:0] evt,
            input logic [31:0] mass, input logic [31:0] lz);
        send_item(OP_QUERY, pack_item('0, '0, '0, '0, '0, uni, evt, mass, lz));
    endtask

    // wait until every answer is back, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [AGE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ASSOC) cur_assoc = val[ASSOC_W-1:0];
        if (idx == CFG_ROWS) begin
            cur_rows = int'(val[RIU_W-1:0]);
            if (cur_rows == 0) cur_rows = 1;
            if (cur_rows > MAX_ROWS) cur_rows = MAX_ROWS;
        end
    endtask

    task automatic set_all(input t_model m, input logic [ASSOC_W-1:0] a,
            input logic [RIU_W-1:0] r, input logic [AGE_W-1:0] late);
        write_reg(CFG_MODEL, AGE_W'(m));
        write_reg(CFG_ASSOC, AGE_W'(a));
        write_reg(CFG_ROWS, AGE_W'(r));
        write_reg(CFG_LATE, late);
    endtask

    // query whose target lands near the span of the loaded curves
    task automatic random_query();
        logic [15:0] evt;
        logic [31:0] mass, lz;
        longint      m;
        evt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        m = (longint'(cur_assoc) + 1) * (longint'(evt) + 1) * 512 * $urandom_range(64, 512) / 256;
        mass = (m > 32'hFFFF_FFFF || $urandom_range(9) == 0) ? $urandom : 32'(m);
        if ($urandom_range(9) == 0) lz = $urandom;
        else lz = 32'(-64'sd2147483648 + longint'($urandom_range(0, cur_rows * 32'h0800_0000)));
        send_query($urandom, evt, mass, lz);
    endtask

    initial begin
        logic [31:0]      cnt;
        logic [AGE_W-1:0] age;
        int               pick;
        logic [AGE_W-1:0] late_pick;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every row and grid point is loaded before any query can read it;
        // counts rise over entries 0..31 with some flat stretches, entry 0 above
        // zero; entry 31 and the bisection pivots 63, 127, ... 1023 hold the top
        // count, so every search settles inside entries 0..31
        for (int r = 0; r < MAX_ROWS; r++) begin
            send_item(OP_LOAD_ROW, pack_item(4'(r), '0, '0, '0,
                32'(-64'sd2147483648 + r * 64'sh0800_0000 + $urandom_range(0, 32'hF_FFFF)),
                '0, '0, '0, '0));
            cnt = $urandom_range(1, 32'h10_0000);
            age = AGE_W'($urandom);
            for (int e = 0; e < 32; e++) begin
                if (e == 31) cnt = '1;
                send_item(OP_LOAD_ENTRY, pack_item(4'(r), 10'(e), age, cnt, '0, '0, '0, '0, '0));
                if ($urandom_range(3) != 0) cnt = cnt + $urandom_range(0, 32'h800_0000);
                age = age + AGE_W'($urandom_range(0, 32'h400_0000));
            end
            for (int e = 63; e < TABLE_SIZE; e = e * 2 + 1) begin
                send_item(OP_LOAD_ENTRY, pack_item(4'(r), 10'(e), age, '1, '0, '0, '0, '0, '0));
                age = age + AGE_W'($urandom_range(0, 32'h400_0000));
            end
        end
        drain();

        // directed: single-row mode with reset settings
        send_query(32'h0, 16'h0, 32'h100, '0);               // zero target, below table
        send_query(32'hFFFF_FFFF, 16'hFFFF, 32'h1, '0);      // huge target, beyond table
        send_query(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0);
        send_query(32'h8000_0000, 16'h0, 32'h0, '0);         // zero mass
        send_query(32'h8000_0000, 16'h0, 32'h200, '0);
        send_item(OP_NONE, pack_item('1, '1, '1, '1, '1, '1, '1, '1, '1));
        drain();
        set_all(MODEL_METAL, 8'd255, 5'd16, '1);
        send_query(32'h1234_5678, 16'h1, 32'h0002_0000, 32'h8000_0000);   // lowest z, row 0
        send_query(32'h1234_5678, 16'h1, 32'h0002_0000, 32'h7FFF_FFFF);   // highest z, last row
        send_query(32'h1234_5678, 16'h1, 32'h0002_0000, 32'hC000_0000);   // between rows
        send_query(32'h0, 16'h0, 32'h0010_0000, 32'h0);
        send_query(32'hFFFF_FFFF, 16'hFFFF, 32'h1, 32'hC800_0000);
        drain();
        set_all(MODEL_SINGLE_B, 8'd0, 5'd0, '0);             // zero rows acts as one
        send_query(32'hFFFF_FFFF, 16'h5, 32'h100, '0);
        drain();
        set_all(MODEL_INVALID, 8'd1, 5'd31, LATE_AGE_RST);  // rows past the maximum
        send_query(32'h1, 16'h1, 32'h100, '0);
        drain();
        write_reg(CFG_MODEL, AGE_W'(MODEL_METAL));
        send_query(32'h4000_0000, 16'h2, 32'h0008_0000, 32'h7FFF_FFFF);
        // extreme entry load at the table end, then an extreme query on that row
        send_item(OP_LOAD_ENTRY, pack_item(4'hF, 10'h3FF, '1, '1, '0, '0, '0, '0, '0));
        send_query(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // random phases, each under its own setting; the idle mix changes at phases 2 and 4
        for (int ph = 0; ph < 7; ph++) begin
            late_pick = {$urandom, $urandom};
            case (ph)
                0: set_all(MODEL_SINGLE_A, 8'd1, 5'd1, LATE_AGE_RST);
                1: set_all(MODEL_METAL, 8'd255, 5'd16, late_pick);
                2: set_all(MODEL_METAL, 8'd3, 5'd5, '1);
                3: set_all(MODEL_SINGLE_B, 8'($urandom_range(1, 255)), 5'd31, late_pick);
                4: set_all(MODEL_METAL, 8'd0, 5'd0, '0);
                5: set_all(MODEL_METAL, 8'($urandom_range(1, 255)), 5'd31, late_pick);
                default: set_all(MODEL_INVALID, 8'd17, 5'd8, late_pick);
            endcase
            if (ph < 2) begin
                src_idle_pct = 6;
                snk_idle_pct = 85;
            end else if (ph < 4) begin
                src_idle_pct = 85;
                snk_idle_pct = 6;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // long stall on the output while the sender keeps offering
            if (ph == 4) hold_req = 1'b1;
            for (int k = 0; k < 160; k++) begin
                pick = $urandom_range(99);
                if (pick < 76) random_query();
                else if (pick < 90)
                    // entries below the pinned top keep every search inside 0..31
                    send_item(OP_LOAD_ENTRY, pack_item(4'($urandom), 10'($urandom_range(0, 30)),
                        {$urandom, $urandom}, $urandom, '0, '0, '0, '0, '0));
                else if (pick < 95)
                    send_item(OP_LOAD_ROW, pack_item(4'($urandom), '0, '0, '0, $urandom,
                        '0, '0, '0, '0));
                else
                    send_item(OP_NONE, pack_item(4'($urandom), 10'($urandom),
                        {$urandom, $urandom}, $urandom, $urandom, $urandom,
                        16'($urandom), $urandom, $urandom));
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
